// ===== hdl/cke_pkg.sv =====
// Shared constants, types and a helper function for the cipher key expansion block.
`default_nettype none

package cke_pkg;

    // Schedule shape.
    localparam int ROUND_KEYS     = 8;
    localparam int PASSES_PER_KEY = 4;

    // Key and word geometry.
    localparam int KEY_W   = 256;
    localparam int WORD_W  = 32;
    localparam int WORDS   = KEY_W / WORD_W;
    localparam int BYTES   = KEY_W / 8;
    localparam int IDX_W   = 6;
    localparam int M_DATA_W = ((KEY_W + IDX_W + 7) / 8) * 8;
    localparam int PAD_W    = M_DATA_W - KEY_W - IDX_W;

    // Counter widths, at least one bit each.
    localparam int RK_CNT_W   = (ROUND_KEYS > 1) ? $clog2(ROUND_KEYS) : 1;
    localparam int PASS_CNT_W = (PASSES_PER_KEY > 1) ? $clog2(PASSES_PER_KEY) : 1;

    localparam logic [RK_CNT_W-1:0]   RK_LAST   = RK_CNT_W'(ROUND_KEYS - 1);
    localparam logic [PASS_CNT_W-1:0] PASS_LAST = PASS_CNT_W'(PASSES_PER_KEY - 1);

    // Rotation amount of the word mix, by destination word.
    localparam int unsigned ROT_AMT [WORDS] = '{17, 23, 7, 13, 29, 21, 19, 15};

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;   // capture a new key
        logic             mix;    // byte steps and word sums of one pass
        logic             add;    // rotate and add that closes one pass
        logic             emit;   // move the working key to the output register
        logic             last;   // the emitted round key is the final one
        logic [IDX_W-1:0] index;  // position of the emitted round key
    } cke_cmd_t;

    // Left rotation of a 32-bit word by a constant amount.
    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                 input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cipher_key_expansion.sv =====
// Top level of the cipher key expansion block: controller plus datapath.
//
//  Channel  Direction  Payload
//  s_       in         tdata[255:0] = key_word0..key_word3, one 256-bit key a beat
//  m_       out        tdata[263:0] = rk_word0..rk_word3, rk_index; tlast = is_last
//
// Each pass of the schedule runs the byte steps and word sums, then the rotate and
// add; a round key takes PASSES_PER_KEY passes and then the load of the output
// register, and a key gives 8 round keys.
// A new key is taken only while no key is in progress; the last round key may still
// wait in the output register. A stalled output register holds the pass loop at
// the emit step. Reset (aresetn low, synchronous) clears the controller only.
`default_nettype none

module cipher_key_expansion (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // key_word0 [63:0], key_word1 [127:64], key_word2 [191:128], key_word3 [255:192]
    input  wire logic [cke_pkg::KEY_W-1:0]         s_tdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // rk_word0 [63:0], rk_word1 [127:64], rk_word2 [191:128], rk_word3 [255:192],
    // rk_index [261:256], zero fill [263:262]
    output logic [cke_pkg::M_DATA_W-1:0]           m_tdata,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);

    cke_pkg::cke_cmd_t cmd;

    cke_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    cke_datapath u_datapath (
        .aclk     (aclk),
        .cmd      (cmd),
        .key_in   (s_tdata),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hdl/cke_ctrl.sv =====
// Controller state machine that sequences passes, round keys and the output beat.
`default_nettype none

module cke_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output cke_pkg::cke_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_ADD,
        ST_EMIT
    } state_t;

    state_t                            state_reg;
    logic [cke_pkg::PASS_CNT_W-1:0]    pass_cnt_reg;
    logic [cke_pkg::RK_CNT_W-1:0]      rk_cnt_reg;
    logic                              m_tvalid_reg;
    logic                              slot_free;

    // The output register can take a beat when empty or being drained.
    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    // Commands decoded from the current state.
    always_comb begin
        cmd       = '0;
        cmd.load  = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mix   = (state_reg == ST_MIX);
        cmd.add   = (state_reg == ST_ADD);
        cmd.emit  = (state_reg == ST_EMIT) && slot_free;
        cmd.last  = (rk_cnt_reg == cke_pkg::RK_LAST);
        cmd.index = cke_pkg::IDX_W'(rk_cnt_reg);
    end

    // State, counters and the output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pass_cnt_reg <= '0;
            rk_cnt_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The output beat is raised on an emit and dropped once taken.
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        pass_cnt_reg <= '0;
                        rk_cnt_reg   <= '0;
                        state_reg    <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    state_reg <= ST_ADD;
                end
                ST_ADD: begin
                    if (pass_cnt_reg == cke_pkg::PASS_LAST) begin
                        pass_cnt_reg <= '0;
                        state_reg    <= ST_EMIT;
                    end else begin
                        pass_cnt_reg <= pass_cnt_reg + 1'b1;
                        state_reg    <= ST_MIX;
                    end
                end
                ST_EMIT: begin
                    if (slot_free) begin
                        if (rk_cnt_reg == cke_pkg::RK_LAST) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            rk_cnt_reg <= rk_cnt_reg + 1'b1;
                            state_reg  <= ST_MIX;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cke_datapath.sv =====
// Datapath: working key, pass logic and the output payload register.
`default_nettype none

module cke_datapath (
    input  wire logic                          aclk,
    input  wire cke_pkg::cke_cmd_t             cmd,
    input  wire logic [cke_pkg::KEY_W-1:0]     key_in,
    output logic [cke_pkg::M_DATA_W-1:0]       out_data,
    output logic                               out_last
);

    logic [cke_pkg::KEY_W-1:0]    key_reg;
    logic [cke_pkg::WORD_W-1:0]   sum_reg [cke_pkg::WORDS];
    logic [cke_pkg::M_DATA_W-1:0] out_data_reg;
    logic                         out_last_reg;

    logic [7:0]                   b1     [cke_pkg::BYTES];
    logic [7:0]                   parity [cke_pkg::WORDS];
    logic [cke_pkg::KEY_W-1:0]    mixed;
    logic [cke_pkg::WORD_W-1:0]   sum_next [cke_pkg::WORDS];
    logic [cke_pkg::KEY_W-1:0]    added;

    // Byte step: each byte is folded with its position and two shifted copies.
    always_comb begin
        for (int i = 0; i < cke_pkg::BYTES; i++) begin
            b1[i] = key_reg[8*i +: 8]
                  ^ (8'(i) ^ {key_reg[8*i +: 7], 1'b0} ^ {4'h0, key_reg[8*i+4 +: 4]});
        end
    end

    // Group step: the first byte of each group gains its rotated group parity.
    always_comb begin
        for (int g = 0; g < cke_pkg::WORDS; g++) begin
            parity[g] = b1[4*g] ^ b1[4*g+1] ^ b1[4*g+2] ^ b1[4*g+3];
            mixed[32*g +: 8]    = b1[4*g] + {parity[g][2:0], parity[g][7:3]};
            mixed[32*g+8 +: 8]  = b1[4*g+1];
            mixed[32*g+16 +: 8] = b1[4*g+2];
            mixed[32*g+24 +: 8] = b1[4*g+3];
        end
    end

    // Neighbor sums of the word mix, registered for the rotate and add that follow.
    always_comb begin
        for (int i = 0; i < cke_pkg::WORDS; i++) begin
            sum_next[i] = (mixed[32*((i+1) % cke_pkg::WORDS) +: 32] ^ mixed[32*i +: 32])
                        + mixed[32*((i + cke_pkg::WORDS - 1) % cke_pkg::WORDS) +: 32];
        end
    end

    // Closing rotate and add of the word mix.
    always_comb begin
        for (int i = 0; i < cke_pkg::WORDS; i++) begin
            added[32*i +: 32] = key_reg[32*i +: 32]
                              + cke_pkg::rotl32(sum_reg[i], cke_pkg::ROT_AMT[i]);
        end
    end

    // Working key and word sums.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg <= key_in;
        end else if (cmd.mix) begin
            key_reg <= mixed;
        end else if (cmd.add) begin
            key_reg <= added;
        end
        if (cmd.mix) begin
            for (int i = 0; i < cke_pkg::WORDS; i++) begin
                sum_reg[i] <= sum_next[i];
            end
        end
    end

    // Output payload register, loaded when a round key is emitted.
    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= {{cke_pkg::PAD_W{1'b0}}, cmd.index, key_reg};
            out_last_reg <= cmd.last;
        end
    end

    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the cipher key expansion block, with its own key schedule predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_KEYS  = 220;
    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_PRINTED  = 30;
    localparam int DIRECTED_N   = 16;

    // Rotation amounts of the word mix, indexed by destination word.
    localparam int MIX_ROT [8] = '{17, 23, 7, 13, 29, 21, 19, 15};

    // Directed keys: extremes, single words, byte patterns and shift corner cases.
    localparam logic [cke_pkg::KEY_W-1:0] DIRECTED_KEYS [DIRECTED_N] = '{
        {cke_pkg::KEY_W{1'b0}},
        {cke_pkg::KEY_W{1'b1}},
        {192'h0, 64'hFFFF_FFFF_FFFF_FFFF},
        {128'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0},
        {64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 128'h0},
        {64'hFFFF_FFFF_FFFF_FFFF, 192'h0},
        {32{8'h55}},
        {32{8'hAA}},
        {255'h0, 1'b1},
        {1'b1, 255'h0},
        256'h1F1E1D1C1B1A19181716151413121110_0F0E0D0C0B0A09080706050403020100,
        {32{8'h80}},
        {32{8'h0F}},
        {32{8'hF0}},
        {8{32'h8000_0001}},
        {8{32'hDEAD_BEEF}}
    };

    typedef struct packed {
        logic [cke_pkg::KEY_W-1:0] key;
        logic [cke_pkg::IDX_W-1:0] index;
        logic                      last;
    } round_key_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic [cke_pkg::KEY_W-1:0]    s_tdata  = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [cke_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tlast;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;

    round_key_t pending_round_keys [$];
    int         idle_phase      = 0;
    int         mismatches      = 0;
    int         keys_accepted   = 0;
    int         rks_checked     = 0;
    int         quiet_cycles    = 0;

    cipher_key_expansion uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 20 ns clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Left rotation of a 32-bit word.
    function automatic logic [31:0] spin32(input logic [31:0] x, input int n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    // One pass of the schedule: byte whitening, group add, then the word mix.
    function automatic logic [cke_pkg::KEY_W-1:0] key_pass(
        input logic [cke_pkg::KEY_W-1:0] st);
        logic [7:0]                b [32];
        logic [31:0]               v [8];
        logic [7:0]                g;
        logic [cke_pkg::KEY_W-1:0] res;
        for (int i = 0; i < 32; i++) begin
            b[i] = st[8*i +: 8];
        end
        for (int i = 0; i < 32; i++) begin
            b[i] = b[i] ^ (8'(i) ^ (b[i] << 1) ^ (b[i] >> 4));
        end
        for (int i = 0; i < 32; i += 4) begin
            g    = b[i] ^ b[i+1] ^ b[i+2] ^ b[i+3];
            b[i] = b[i] + {g[2:0], g[7:3]};
        end
        for (int i = 0; i < 8; i++) begin
            v[i] = {b[4*i+3], b[4*i+2], b[4*i+1], b[4*i]};
        end
        // Every word mixes with its upper and lower neighbor, all from before this step.
        for (int i = 0; i < 8; i++) begin
            res[32*i +: 32] = v[i] + spin32((v[(i+1)%8] ^ v[i]) + v[(i+7)%8], MIX_ROT[i]);
        end
        return res;
    endfunction

    // Queue every round key that one accepted key will produce.
    task automatic expand_key(input logic [cke_pkg::KEY_W-1:0] k);
        logic [cke_pkg::KEY_W-1:0] st;
        round_key_t                rk;
        st = k;
        for (int r = 0; r < cke_pkg::ROUND_KEYS; r++) begin
            for (int p = 0; p < cke_pkg::PASSES_PER_KEY; p++) begin
                st = key_pass(st);
            end
            rk.key   = st;
            rk.index = cke_pkg::IDX_W'(r);  // wraps modulo 64 on a long schedule
            rk.last  = (r == cke_pkg::ROUND_KEYS - 1);
            pending_round_keys.push_back(rk);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_PRINTED) begin
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // Random key: dense in half the cases, some bytes forced to 00/FF in a quarter, sparse in a quarter.
    function automatic logic [cke_pkg::KEY_W-1:0] random_key();
        logic [cke_pkg::KEY_W-1:0] k;
        int                        mode;
        mode = $urandom_range(3);
        for (int i = 0; i < 8; i++) begin
            k[32*i +: 32] = $urandom;
        end
        if (mode == 0) begin
            for (int i = 0; i < 32; i++) begin
                case ($urandom_range(2))
                    0: k[8*i +: 8] = 8'h00;
                    1: k[8*i +: 8] = 8'hFF;
                    default: ;
                endcase
            end
        end else if (mode == 1) begin
            for (int i = 0; i < 8; i++) begin
                k[32*i +: 32] = $urandom & $urandom & $urandom;
            end
        end
        return k;
    endfunction

    // Offer one key beat, after a random gap, and wait for it to be taken.
    task automatic send_key(input logic [cke_pkg::KEY_W-1:0] k);
        int pct;
        pct = (idle_phase == 0) ? 22 : (idle_phase == 1) ? 76 : 0;
        while ($urandom_range(99) < pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = k;
        s_tvalid = 1'b1;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    // Result side: random back-pressure, and one long hold-off at the start of the last mix.
    initial begin : result_sink
        bit held;
        int pct;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_phase == 2 && !held) begin
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            pct      = (idle_phase == 0) ? 76 : (idle_phase == 1) ? 22 : 0;
            m_tready = ($urandom_range(99) >= pct);
        end
    end

    // Check each round key beat against the oldest prediction, then predict new keys.
    always @(posedge aclk) begin : scoreboard
        round_key_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_round_keys.size() == 0) begin
                    report_mismatch("round key with none expected", m_tdata[63:0], 64'h0);
                end else begin
                    want = pending_round_keys.pop_front();
                    for (int j = 0; j < 4; j++) begin
                        if (m_tdata[64*j +: 64] !== want.key[64*j +: 64]) begin
                            report_mismatch($sformatf("rk_word%0d", j),
                                            m_tdata[64*j +: 64], want.key[64*j +: 64]);
                        end
                    end
                    if (m_tdata[cke_pkg::KEY_W +: cke_pkg::IDX_W] !== want.index) begin
                        report_mismatch("rk_index",
                                        64'(m_tdata[cke_pkg::KEY_W +: cke_pkg::IDX_W]),
                                        64'(want.index));
                    end
                    if (m_tlast !== want.last) begin
                        report_mismatch("is_last", 64'(m_tlast), 64'(want.last));
                    end
                    if (m_tdata[cke_pkg::M_DATA_W-1:cke_pkg::KEY_W+cke_pkg::IDX_W] !== '0)
                    begin
                        report_mismatch("zero fill",
                            64'(m_tdata[cke_pkg::M_DATA_W-1:cke_pkg::KEY_W+cke_pkg::IDX_W]),
                            64'h0);
                    end
                    rks_checked++;
                end
            end
            if (s_tvalid && s_tready) begin
                expand_key(s_tdata);
                keys_accepted++;
            end
        end
    end

    // Watchdog on cycles with no beat on either side.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed keys, random keys, drain and verdict.
    initial begin : stimulus
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int n = 0; n < DIRECTED_N; n++) begin
            send_key(DIRECTED_KEYS[n]);
        end
        for (int n = 0; n < RANDOM_KEYS; n++) begin
            if (n == RANDOM_KEYS / 3) begin
                idle_phase = 1;
            end else if (n == 2 * RANDOM_KEYS / 3) begin
                idle_phase = 2;
            end
            send_key(random_key());
        end
        s_tvalid = 1'b0;

        while (pending_round_keys.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Expanded %0d keys into %0d checked round keys under three idling mixes",
                 keys_accepted, rks_checked);
        $display("and one long output hold-off; %0d field mismatches seen.", mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
